FILE: src/bcfe_pkg.sv
// bcfe_pkg: request and result types and framing constants for the
// binary command frame encoder; no dependencies
package bcfe_pkg;

  localparam int unsigned CountWidth = 14;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned LenWidth   = 16;

  localparam logic [CountWidth-1:0] MAX_PAYLOAD_WORDS = CountWidth'(16383);

  localparam logic [7:0] SYNC_FIRST  = 8'hBA;
  localparam logic [7:0] SYNC_SECOND = 8'hCE;

  typedef struct packed {
    logic                  first_item;
    logic [7:0]            msg_class;
    logic [7:0]            msg_code;
    logic [CountWidth-1:0] word_count;
    logic [WordWidth-1:0]  payload_word;
  } bcfe_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } bcfe_rsp_t;

endpackage

FILE: src/binary_command_frame_encoder_unit.sv
// binary_command_frame_encoder_unit: frame state update, byte job register and
// output register of the binary command frame encoder; depends on bcfe_pkg
//
// path: an accepted request is loaded into the job register, and its bytes leave through the output register
// throughput: one frame byte per cycle while the output is not stalled by tx_ready,
//   set by the single byte-wide output register; a payload request emits 4 bytes,
//   one that also ends the frame 8, a frame start 10 (empty frame, or a frame
//   left open after its first word) or 14 (single-word frame)
// reset: synchronous, clears frame state, job valid, byte pointer and output valid
module binary_command_frame_encoder_unit
  import bcfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  bcfe_req_t cmd,
  output logic      tx_valid,
  input  logic      tx_ready,
  output bcfe_rsp_t tx
);

  // byte positions in a full job: header, payload word, checksum
  localparam logic [3:0] POS_SYNC1 = 4'd0;
  localparam logic [3:0] POS_SYNC2 = 4'd1;
  localparam logic [3:0] POS_LEN0  = 4'd2;
  localparam logic [3:0] POS_LEN1  = 4'd3;
  localparam logic [3:0] POS_CLASS = 4'd4;
  localparam logic [3:0] POS_ID    = 4'd5;
  localparam logic [3:0] POS_WORD0 = 4'd6;
  localparam logic [3:0] POS_WORD1 = 4'd7;
  localparam logic [3:0] POS_WORD2 = 4'd8;
  localparam logic [3:0] POS_WORD3 = 4'd9;
  localparam logic [3:0] POS_CK0   = 4'd10;
  localparam logic [3:0] POS_CK1   = 4'd11;
  localparam logic [3:0] POS_CK2   = 4'd12;
  localparam logic [3:0] POS_CK3   = 4'd13;

  // everything one request emits, fixed at acceptance
  typedef struct packed {
    logic                 hdr_en;
    logic                 word_en;
    logic                 sum_en;
    logic [7:0]           msg_class;
    logic [7:0]           msg_code;
    logic [LenWidth-1:0]  len;
    logic [WordWidth-1:0] word;
    logic [WordWidth-1:0] sum;
  } bcfe_job_t;

  // frame state
  logic                  frame_open, frame_open_next;
  logic [CountWidth-1:0] words_left, words_left_next;
  logic [WordWidth-1:0]  running_sum, running_sum_next;

  // job register and byte pointer
  logic                  job_valid;
  bcfe_job_t             job, job_next;
  logic [3:0]            idx, idx_next;
  logic                  job_load;

  // request decode
  logic                  accept;
  logic [CountWidth-1:0] cnt;
  logic [LenWidth-1:0]   len;
  logic [WordWidth-1:0]  seed;
  logic [WordWidth-1:0]  base_sum;
  logic [WordWidth-1:0]  sum_after;
  logic [CountWidth-1:0] base_left;
  logic [CountWidth-1:0] left_after;

  // byte emission
  logic                  emit;
  logic                  job_last;
  logic                  job_done;
  bcfe_rsp_t             cur;

  assign accept = cmd_valid && cmd_ready;

  // word count is held to the frame limit before length and seed are formed
  assign cnt  = (cmd.word_count > MAX_PAYLOAD_WORDS) ? MAX_PAYLOAD_WORDS : cmd.word_count;
  assign len  = LenWidth'({cnt, 2'b00});
  assign seed = {cmd.msg_code, cmd.msg_class, len};

  // a frame start restarts the sum from the seed, otherwise it continues
  assign base_sum   = cmd.first_item ? seed : running_sum;
  assign base_left  = cmd.first_item ? cnt : words_left;
  assign sum_after  = base_sum + cmd.payload_word;
  assign left_after = base_left - CountWidth'(1);

  always_comb begin
    frame_open_next  = frame_open;
    words_left_next  = words_left;
    running_sum_next = running_sum;
    job_load         = 1'b0;
    job_next         = '0;
    job_next.msg_class  = cmd.msg_class;
    job_next.msg_code   = cmd.msg_code;
    job_next.len        = len;
    job_next.word       = cmd.payload_word;
    job_next.sum        = sum_after;

    if (cmd.first_item) begin
      job_load        = 1'b1;
      job_next.hdr_en = 1'b1;
      if (cnt == '0) begin
        // empty frame: header then checksum of the seed alone
        job_next.sum_en  = 1'b1;
        job_next.sum     = seed;
        running_sum_next = seed;
        frame_open_next  = 1'b0;
        words_left_next  = '0;
      end else begin
        job_next.word_en = 1'b1;
        running_sum_next = sum_after;
        if (left_after == '0) begin
          job_next.sum_en = 1'b1;
          frame_open_next = 1'b0;
          words_left_next = '0;
        end else begin
          frame_open_next = 1'b1;
          words_left_next = left_after;
        end
      end
    end else if (frame_open) begin
      if (words_left == '0) begin
        // open frame with nothing left: close silently
        frame_open_next = 1'b0;
      end else begin
        job_load         = 1'b1;
        job_next.word_en = 1'b1;
        running_sum_next = sum_after;
        if (left_after == '0) begin
          job_next.sum_en = 1'b1;
          frame_open_next = 1'b0;
          words_left_next = '0;
        end else begin
          words_left_next = left_after;
        end
      end
    end
    // requests with no frame open leave everything as it is
  end

  // current byte of the job
  always_comb begin
    cur.frame_end = 1'b0;
    unique case (idx)
      POS_SYNC1: cur.out_byte = SYNC_FIRST;
      POS_SYNC2: cur.out_byte = SYNC_SECOND;
      POS_LEN0:  cur.out_byte = job.len[7:0];
      POS_LEN1:  cur.out_byte = job.len[15:8];
      POS_CLASS: cur.out_byte = job.msg_class;
      POS_ID:    cur.out_byte = job.msg_code;
      POS_WORD0: cur.out_byte = job.word[7:0];
      POS_WORD1: cur.out_byte = job.word[15:8];
      POS_WORD2: cur.out_byte = job.word[23:16];
      POS_WORD3: cur.out_byte = job.word[31:24];
      POS_CK0:   cur.out_byte = job.sum[7:0];
      POS_CK1:   cur.out_byte = job.sum[15:8];
      POS_CK2:   cur.out_byte = job.sum[23:16];
      POS_CK3: begin
        cur.out_byte  = job.sum[31:24];
        cur.frame_end = 1'b1;
      end
      default:   cur.out_byte = '0;
    endcase
  end

  // the job ends on the last checksum byte, or on the last word byte if the
  // frame stays open
  assign job_last = job.sum_en ? (idx == POS_CK3) : (idx == POS_WORD3);
  assign emit     = job_valid && (!tx_valid || tx_ready);
  assign job_done = emit && job_last;

  // next request is taken while the last byte of the current one moves out
  assign cmd_ready = !job_valid || job_done;

  // byte pointer: skip the payload bytes for an empty frame
  always_comb begin
    idx_next = idx + 4'd1;
    if (idx == POS_ID && !job.word_en) begin
      idx_next = POS_CK0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      words_left  <= '0;
      running_sum <= '0;
      job_valid   <= 1'b0;
      idx         <= POS_SYNC1;
      tx_valid    <= 1'b0;
    end else begin
      if (accept) begin
        frame_open  <= frame_open_next;
        words_left  <= words_left_next;
        running_sum <= running_sum_next;
      end

      if (accept && job_load) begin
        job_valid <= 1'b1;
        idx       <= job_next.hdr_en ? POS_SYNC1 : POS_WORD0;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx_next;
      end

      if (emit) begin
        tx_valid <= 1'b1;
      end else if (tx_ready) begin
        tx_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && job_load) begin
      job <= job_next;
    end
    if (emit) begin
      tx <= cur;
    end
  end

  // pointer never runs past the final checksum byte
  a_idx_range : assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (idx <= POS_CK3))
    else $error("byte pointer out of range");

  // an open frame always expects at least one more word
  a_open_left : assert property (@(posedge clk) disable iff (rst)
    frame_open |-> (words_left != '0))
    else $error("open frame with no words left");

  // a loaded job always carries payload or checksum bytes
  a_job_content : assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.word_en || job.sum_en))
    else $error("job without payload or checksum");

endmodule
